[sv/double_ended_queue_macros.svh]
// ----------------------------------------------------------------------------
// double_ended_queue assertion macros
// shared concurrent assertion forms, clocked on clk_i and held off in reset
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication
`define DEQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("double_ended_queue: same-cycle check failed");

// next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("double_ended_queue: next-cycle check failed");

`endif

[sv/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// shared constants, codes and control types of the double-ended queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int FUNC_W    = 3;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;

  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LIST       = 3'd4;

  localparam logic [STAT_W-1:0] STS_POP   = 2'd0;
  localparam logic [STAT_W-1:0] STS_LIST  = 2'd1;
  localparam logic [STAT_W-1:0] STS_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STS_FULL  = 2'd3;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic list_first;
    logic list_next;
    logic emit_pop;
    logic emit_full;
    logic emit_empty;
  } deq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic list_done;
  } deq_sts_t;

endpackage

[sv/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// operation sequencer: decodes each word and steps pops and list walks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"

module deq_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [deq_pkg::FUNC_W-1:0]   func_i,
  input  deq_pkg::deq_sts_t            sts_i,
  output deq_pkg::deq_cmd_t            cmd_o,
  output logic                         busy_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_LIST = 2'd2;

  logic [1:0]        state_q, state_d;
  deq_pkg::deq_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (func_i)
            deq_pkg::FN_PUSH_FRONT: begin
              if (sts_i.full) cmd.emit_full = 1'b1;
              else cmd.push_front = 1'b1;
            end
            deq_pkg::FN_PUSH_BACK: begin
              if (sts_i.full) cmd.emit_full = 1'b1;
              else cmd.push_back = 1'b1;
            end
            deq_pkg::FN_POP_FRONT: begin
              if (!sts_i.empty) begin
                cmd.pop_front = 1'b1;
                state_d       = ST_POP;
              end
            end
            deq_pkg::FN_POP_BACK: begin
              if (!sts_i.empty) begin
                cmd.pop_back = 1'b1;
                state_d      = ST_POP;
              end
            end
            deq_pkg::FN_LIST: begin
              if (sts_i.empty) begin
                cmd.emit_empty = 1'b1;
              end else begin
                cmd.list_first = 1'b1;
                state_d        = ST_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        cmd.emit_pop = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_LIST: begin
        cmd.list_next = 1'b1;
        if (sts_i.list_done) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != ST_IDLE);

  `DEQ_ASSERT_IMPL(a_one_emit, 1'b1, $onehot0({cmd.emit_pop, cmd.emit_full, cmd.emit_empty, cmd.list_next}))
  `DEQ_ASSERT_NEXT(a_pop_one_cycle, state_q == ST_POP, state_q == ST_IDLE)
  `DEQ_ASSERT_NEXT(a_pop_enters, cmd.pop_front || cmd.pop_back, state_q == ST_POP)

endmodule

[sv/deq_dp.sv]
// ----------------------------------------------------------------------------
// deq_dp
// ring storage, front index, occupancy, list counter and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"

module deq_dp #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  deq_pkg::deq_cmd_t                  cmd_i,
  input  logic signed [deq_pkg::DATA_W-1:0]  value_i,
  output deq_pkg::deq_sts_t                  sts_o,
  output logic                               strobe_o,
  output logic signed [deq_pkg::DATA_W-1:0]  value_res_o,
  output logic [deq_pkg::STAT_W-1:0]         status_o,
  output logic                               last_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [AW-1:0]                front_q, front_d;
  logic [CW-1:0]                occ_q, occ_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [AW-1:0]                front_dec, front_inc;
  logic [AW-1:0]                waddr, raddr;
  logic                         we;
  logic [deq_pkg::DATA_W-1:0]   rdata;
  logic                         strobe_q, strobe_d;
  logic [deq_pkg::DATA_W-1:0]   value_q, value_d;
  logic [deq_pkg::STAT_W-1:0]   status_q, status_d;
  logic                         last_q, last_d;
  deq_pkg::deq_sts_t            sts;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
    return sum[AW-1:0];
  endfunction

  assign sts.full      = (occ_q == CW'(DEPTH));
  assign sts.empty     = (occ_q == '0);
  assign sts.list_done = (cnt_q == occ_q);
  assign sts_o         = sts;

  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;

  assign we    = cmd_i.push_front | cmd_i.push_back;
  assign waddr = cmd_i.push_front ? front_dec : wrap_add(front_q, occ_q);

  always_comb begin
    raddr = front_q;
    if (cmd_i.pop_back) raddr = wrap_add(front_q, occ_q - 1'b1);
    else if (cmd_i.list_next) raddr = wrap_add(front_q, cnt_q);
  end

  deq_ram #(
    .WIDTH(deq_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    front_d = front_q;
    occ_d   = occ_q;
    cnt_d   = cnt_q;
    if (cmd_i.push_front) begin
      front_d = front_dec;
      occ_d   = occ_q + 1'b1;
    end else if (cmd_i.push_back) begin
      occ_d = occ_q + 1'b1;
    end else if (cmd_i.pop_front) begin
      front_d = front_inc;
      occ_d   = occ_q - 1'b1;
    end else if (cmd_i.pop_back) begin
      occ_d = occ_q - 1'b1;
    end
    if (cmd_i.list_first) cnt_d = CW'(1);
    else if (cmd_i.list_next && !sts.list_done) cnt_d = cnt_q + 1'b1;
  end

  always_comb begin
    strobe_d = cmd_i.emit_pop | cmd_i.emit_full | cmd_i.emit_empty | cmd_i.list_next;
    value_d  = '0;
    status_d = deq_pkg::STS_POP;
    last_d   = 1'b1;
    if (cmd_i.emit_full) begin
      status_d = deq_pkg::STS_FULL;
    end else if (cmd_i.emit_empty) begin
      status_d = deq_pkg::STS_EMPTY;
    end else if (cmd_i.emit_pop) begin
      value_d = rdata;
    end else if (cmd_i.list_next) begin
      value_d  = rdata;
      status_d = deq_pkg::STS_LIST;
      last_d   = sts.list_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      occ_q    <= '0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      front_q  <= front_d;
      occ_q    <= occ_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign strobe_o    = strobe_q;
  assign value_res_o = value_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  `DEQ_ASSERT_IMPL(a_occ_range, 1'b1, occ_q <= CW'(DEPTH))
  `DEQ_ASSERT_IMPL(a_push_room, cmd_i.push_front || cmd_i.push_back, !sts.full)
  `DEQ_ASSERT_NEXT(a_push_grows, cmd_i.push_front || cmd_i.push_back, occ_q == CW'($past(occ_q) + 1'b1))

endmodule

[sv/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue of signed 32-bit words held in a ring of DEPTH
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a word (func_i, value_i) is taken on a rising edge with
//   start high and busy low. Result channel: strobe_o marks one cycle of
//   value_res_o, status_o and last_o; the receiver must take it then.
//   Behaviour per word, from the accepting edge:
//     push front/back: written at that edge, busy stays low; a push into
//       a full ring gives one full result in the next cycle.
//     pop front/back: read via the RAM read register, then the result
//       register, busy until it is sent; pop of an empty queue gives nothing.
//     list: one result per held word, the first through the RAM read and
//       result registers, then one each cycle out of the single RAM read port;
//       busy till the last is sent. An empty list gives one marker next cycle.
//   A new word may be taken while a result is still on the output.
//   Reset (rst_ni low) empties the queue at once; ring contents are kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [deq_pkg::FUNC_W-1:0]         func_i,
  input  logic signed [deq_pkg::DATA_W-1:0]  value_i,
  output logic                               strobe_o,
  output logic signed [deq_pkg::DATA_W-1:0]  value_res_o,
  output logic [deq_pkg::STAT_W-1:0]         status_o,
  output logic                               last_o
);

  deq_pkg::deq_cmd_t cmd;
  deq_pkg::deq_sts_t sts;

  deq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  deq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (value_i),
    .sts_o      (sts),
    .strobe_o   (strobe_o),
    .value_res_o(value_res_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

endmodule
